// ===== src/pac_pkg.sv =====
`default_nettype none

package pac_pkg;

	// Field widths of the stream payloads.
	localparam int XW      = 16;
	localparam int YW      = 16;
	localparam int IN_W    = XW + YW;
	localparam int AREA_W  = 31;
	localparam int OUT_W   = 64;
	localparam int OUT_PAD = OUT_W - AREA_W - XW - YW;

	// Accumulator and datapath widths.
	localparam int DA_W   = 48;
	localparam int MOM_W  = 64;
	localparam int DEN_W  = DA_W + 2;
	localparam int DACC_W = XW + YW + 4;
	localparam int MAG_W  = XW + YW;
	localparam int SUM_W  = YW + 3;
	localparam int MA_W   = MAG_W + 1;
	localparam int MB_W   = SUM_W;
	localparam int PROD_W = MA_W + MB_W;

	// Saturation limits and result clamps.
	localparam logic [DA_W-1:0]   DA_MAX    = {DA_W{1'b1}};
	localparam logic [AREA_W-1:0] AREA_MAX  = {AREA_W{1'b1}};
	localparam logic [MOM_W-1:0]  MOM_MAX   = {1'b0, {(MOM_W-1){1'b1}}};
	localparam logic [MOM_W-1:0]  MOM_MIN   = {1'b1, {(MOM_W-1){1'b0}}};
	localparam logic [MOM_W-1:0]  X_POS_LIM = MOM_W'(2**(XW-1) - 1);
	localparam logic [MOM_W-1:0]  X_NEG_LIM = MOM_W'(2**(XW-1));
	localparam logic [MOM_W-1:0]  Y_LIM     = MOM_W'(2**YW - 1);

	// One polyline vertex; packed so that x sits in the low bits.
	typedef struct packed {
		logic [YW-1:0]        y;
		logic signed [XW-1:0] x;
	} vertex_t;

endpackage

`default_nettype wire

// ===== src/pac_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle, unsigned operands.
module pac_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pac_pkg::MOM_W-1:0]   dividend,
	input  logic [pac_pkg::DEN_W-1:0]   divisor,
	output logic                        done,
	output logic [pac_pkg::MOM_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(pac_pkg::MOM_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [pac_pkg::MOM_W-1:0]   quo_q;
	logic [pac_pkg::DEN_W-1:0]   rem_q;
	logic [pac_pkg::DEN_W-1:0]   dsr_q;
	logic [pac_pkg::DEN_W:0]     trial;
	logic [pac_pkg::DEN_W:0]     diff;
	logic                        ge;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quo_q[pac_pkg::MOM_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	// Sequencing of the bit steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(pac_pkg::MOM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits replace the dividend bits as they are consumed.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[pac_pkg::MOM_W-2:0], ge};
			rem_q <= ge ? diff[pac_pkg::DEN_W-1:0] : trial[pac_pkg::DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== src/polyline_area_centroid.sv =====
`default_nettype none

// Area and centroid of a piecewise-linear membership function. Points arrive one item
// at a time on the slave stream (x signed, degree Q1.15, tlast on the final point).
// The first two points of a term are only shifted into the window. Every later point
// adds two triangles, and each triangle runs eight steps through one shared,
// registered 33 x 19 bit multiplier (three products for the doubled area, two for the
// moments), during which tready is low. After the last point, when three or more
// points came and the area is nonzero, two 64-step restoring divisions (one quotient
// bit per cycle) produce center_x and center_y. The result item is loaded into the
// output register from S_EMIT; tready stays low until then, and longer while an
// earlier result item still waits in the output register. One result item follows
// each item with tlast set; result_valid in tuser is low, and the data zero, when
// fewer than three points came or the area is zero. Sums saturate, and the block
// clears its term state when the result is loaded into the output register.
module polyline_area_centroid (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// point_x [15:0], point_y [31:16]
	input  logic [pac_pkg::IN_W-1:0]     s_tdata,
	// last_point
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// area_value [30:0], center_x [46:31], center_y [62:47], zero [63]
	output logic [pac_pkg::OUT_W-1:0]    m_tdata,
	// result_valid
	output logic                         m_tuser
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL0 = 4'd1;
	localparam logic [3:0] S_MUL1 = 4'd2;
	localparam logic [3:0] S_MUL2 = 4'd3;
	localparam logic [3:0] S_DSUM = 4'd4;
	localparam logic [3:0] S_AREA = 4'd5;
	localparam logic [3:0] S_MOMX = 4'd6;
	localparam logic [3:0] S_MOMY = 4'd7;
	localparam logic [3:0] S_MACC = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;
	localparam logic [3:0] S_DIVX = 4'd10;
	localparam logic [3:0] S_DIVY = 4'd11;
	localparam logic [3:0] S_EMIT = 4'd12;

	localparam logic [1:0] SEEN_TWO  = 2'd2;
	localparam logic [1:0] SEEN_MANY = 2'd3;

	logic [3:0]                         state_q;
	logic [1:0]                         seen_q;
	logic                               phase_q;
	logic                               last_q;
	pac_pkg::vertex_t                   win_q [3];
	pac_pkg::vertex_t                   pt_q;
	pac_pkg::vertex_t                   in_pt;
	pac_pkg::vertex_t                   foot;
	pac_pkg::vertex_t                   win_in;
	logic                               win_shift;
	logic                               in_fire;
	logic                               emit_fire;

	logic signed [pac_pkg::MA_W-1:0]    mul_a;
	logic signed [pac_pkg::MB_W-1:0]    mul_b;
	logic signed [pac_pkg::PROD_W-1:0]  mul_q;
	logic signed [pac_pkg::DACC_W-1:0]  d_q;
	logic signed [pac_pkg::DACC_W-1:0]  abs_d;
	logic [pac_pkg::MAG_W-1:0]          a_q;

	logic signed [pac_pkg::YW:0]        dy12;
	logic signed [pac_pkg::YW:0]        dy20;
	logic signed [pac_pkg::YW:0]        dy01;
	logic signed [pac_pkg::SUM_W-1:0]   sx;
	logic [pac_pkg::SUM_W-2:0]          sy;

	logic [pac_pkg::DA_W-1:0]           das_q;
	logic [pac_pkg::DA_W:0]             das_sum;
	logic signed [pac_pkg::MOM_W-1:0]   mx_q;
	logic signed [pac_pkg::MOM_W-1:0]   my_q;
	logic [pac_pkg::MOM_W-1:0]          mx_mag;
	logic [pac_pkg::MOM_W-1:0]          my_mag;
	logic [pac_pkg::DA_W-2:0]           area_full;
	logic [pac_pkg::AREA_W-1:0]         area;

	logic                               div_start;
	logic                               div_done;
	logic [pac_pkg::MOM_W-1:0]          div_dvd;
	logic [pac_pkg::DEN_W-1:0]          div_den;
	logic [pac_pkg::MOM_W-1:0]          div_quo;

	logic                               res_ok_q;
	logic                               neg_q;
	logic [pac_pkg::XW-1:0]             cx_q;
	logic [pac_pkg::YW-1:0]             cy_q;
	logic                               m_tvalid_q;
	logic [pac_pkg::OUT_W-1:0]          m_tdata_q;
	logic                               m_tuser_q;

	// Signed saturating add of a product onto a moment sum.
	function automatic logic signed [pac_pkg::MOM_W-1:0] mom_add(
		input logic signed [pac_pkg::MOM_W-1:0]  acc,
		input logic signed [pac_pkg::PROD_W-1:0] p
	);
		logic signed [pac_pkg::MOM_W:0] s;
		s = (pac_pkg::MOM_W+1)'(acc) + (pac_pkg::MOM_W+1)'(p);
		if (s[pac_pkg::MOM_W] != s[pac_pkg::MOM_W-1]) begin
			return s[pac_pkg::MOM_W] ? pac_pkg::MOM_MIN : pac_pkg::MOM_MAX;
		end
		return s[pac_pkg::MOM_W-1:0];
	endfunction

	// Signed x centroid from sign and quotient magnitude, clamped to the x range.
	function automatic logic [pac_pkg::XW-1:0] clamp_x(
		input logic                       neg,
		input logic [pac_pkg::MOM_W-1:0]  q
	);
		logic [pac_pkg::MOM_W-1:0] nq;
		nq = '0 - q;
		if (!neg) begin
			return (q > pac_pkg::X_POS_LIM) ? {1'b0, {(pac_pkg::XW-1){1'b1}}}
				: q[pac_pkg::XW-1:0];
		end
		return (q > pac_pkg::X_NEG_LIM) ? {1'b1, {(pac_pkg::XW-1){1'b0}}}
			: nq[pac_pkg::XW-1:0];
	endfunction

	// Degree centroid, clamped to the unsigned field.
	function automatic logic [pac_pkg::YW-1:0] clamp_y(
		input logic                       neg,
		input logic [pac_pkg::MOM_W-1:0]  q
	);
		if (neg) begin
			return '0;
		end
		return (q > pac_pkg::Y_LIM) ? {pac_pkg::YW{1'b1}} : q[pac_pkg::YW-1:0];
	endfunction

	assign in_pt     = s_tdata;
	assign s_tready  = (state_q == S_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign emit_fire = (state_q == S_EMIT) && (!m_tvalid_q || m_tready);
	assign foot      = '{y: '0, x: win_q[2].x};

	// Window shift: new point or foot on accept, held point after the first triangle.
	always_comb begin
		win_shift = 1'b0;
		win_in    = in_pt;
		if (in_fire) begin
			win_shift = 1'b1;
			win_in    = (seen_q < SEEN_TWO) ? in_pt : foot;
		end else if (state_q == S_MACC && !phase_q) begin
			win_shift = 1'b1;
			win_in    = pt_q;
		end
	end

	// Triangle terms taken from the three window vertices.
	assign dy12 = $signed({1'b0, win_q[1].y}) - $signed({1'b0, win_q[2].y});
	assign dy20 = $signed({1'b0, win_q[2].y}) - $signed({1'b0, win_q[0].y});
	assign dy01 = $signed({1'b0, win_q[0].y}) - $signed({1'b0, win_q[1].y});
	assign sx   = pac_pkg::SUM_W'(win_q[0].x) + pac_pkg::SUM_W'(win_q[1].x)
		+ pac_pkg::SUM_W'(win_q[2].x);
	assign sy   = (pac_pkg::SUM_W-1)'(win_q[0].y) + (pac_pkg::SUM_W-1)'(win_q[1].y)
		+ (pac_pkg::SUM_W-1)'(win_q[2].y);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MUL0: begin
				mul_a = pac_pkg::MA_W'(win_q[0].x);
				mul_b = pac_pkg::MB_W'(dy12);
			end
			S_MUL1: begin
				mul_a = pac_pkg::MA_W'(win_q[1].x);
				mul_b = pac_pkg::MB_W'(dy20);
			end
			S_MUL2: begin
				mul_a = pac_pkg::MA_W'(win_q[2].x);
				mul_b = pac_pkg::MB_W'(dy01);
			end
			S_MOMX: begin
				mul_a = $signed({1'b0, a_q});
				mul_b = sx;
			end
			S_MOMY: begin
				mul_a = $signed({1'b0, a_q});
				mul_b = $signed({1'b0, sy});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Absolute doubled area and saturating area accumulation.
	assign abs_d   = d_q[pac_pkg::DACC_W-1] ? -d_q : d_q;
	assign das_sum = {1'b0, das_q} + (pac_pkg::DA_W+1)'(a_q);

	// Final quantities: magnitudes for the divider, three times the doubled area.
	assign mx_mag    = mx_q[pac_pkg::MOM_W-1] ? ('0 - mx_q) : mx_q;
	assign my_mag    = my_q[pac_pkg::MOM_W-1] ? ('0 - my_q) : my_q;
	assign div_den   = {2'b00, das_q} + {1'b0, das_q, 1'b0};
	assign div_start = (state_q == S_FIN && seen_q == SEEN_MANY && das_q != '0)
		|| (state_q == S_DIVX && div_done);
	assign div_dvd   = (state_q == S_FIN) ? mx_mag : my_mag;
	assign area_full = das_q[pac_pkg::DA_W-1:1];
	assign area      = (area_full > (pac_pkg::DA_W-1)'(pac_pkg::AREA_MAX))
		? pac_pkg::AREA_MAX : area_full[pac_pkg::AREA_W-1:0];

	pac_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sequencer, term sums and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			seen_q     <= '0;
			phase_q    <= 1'b0;
			das_q      <= '0;
			mx_q       <= '0;
			my_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (seen_q < SEEN_TWO) begin
							seen_q <= seen_q + 2'd1;
							if (s_tlast) begin
								state_q <= S_FIN;
							end
						end else begin
							phase_q <= 1'b0;
							state_q <= S_MUL0;
						end
					end
				end
				S_MUL0: state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_DSUM;
				S_DSUM: state_q <= S_AREA;
				S_AREA: state_q <= S_MOMX;
				S_MOMX: begin
					das_q   <= das_sum[pac_pkg::DA_W] ? pac_pkg::DA_MAX
						: das_sum[pac_pkg::DA_W-1:0];
					state_q <= S_MOMY;
				end
				S_MOMY: begin
					mx_q    <= mom_add(mx_q, mul_q);
					state_q <= S_MACC;
				end
				S_MACC: begin
					my_q <= mom_add(my_q, mul_q);
					if (!phase_q) begin
						phase_q <= 1'b1;
						state_q <= S_MUL0;
					end else begin
						seen_q  <= SEEN_MANY;
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					state_q <= div_start ? S_DIVX : S_EMIT;
				end
				S_DIVX: begin
					if (div_done) begin
						state_q <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_fire) begin
						seen_q  <= '0;
						das_q   <= '0;
						mx_q    <= '0;
						my_q    <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers: window, products, doubled area and centroid results.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pt_q   <= in_pt;
			last_q <= s_tlast;
		end
		if (win_shift) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_in;
		end
		mul_q <= mul_a * mul_b;
		case (state_q)
			S_MUL1: d_q <= $signed(mul_q[pac_pkg::DACC_W-1:0]);
			S_MUL2, S_DSUM: d_q <= d_q + $signed(mul_q[pac_pkg::DACC_W-1:0]);
			S_AREA: a_q <= abs_d[pac_pkg::MAG_W-1:0];
			S_FIN: begin
				res_ok_q <= div_start;
				neg_q    <= mx_q[pac_pkg::MOM_W-1];
			end
			S_DIVX: begin
				if (div_done) begin
					cx_q  <= clamp_x(neg_q, div_quo);
					neg_q <= my_q[pac_pkg::MOM_W-1];
				end
			end
			S_DIVY: begin
				if (div_done) begin
					cy_q <= clamp_y(neg_q, div_quo);
				end
			end
			default: begin
			end
		endcase
		if (emit_fire) begin
			m_tdata_q <= res_ok_q ? {{pac_pkg::OUT_PAD{1'b0}}, cy_q, cx_q, area} : '0;
			m_tuser_q <= res_ok_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// ===== src/pac_chk.sv =====
`default_nettype none

// Port-level checks for the polyline area and centroid block.
module pac_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        s_tlast,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [pac_pkg::OUT_W-1:0]   m_tdata,
	input logic                        m_tuser
);

	// An invalid result carries all-zero data.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("invalid result item with nonzero data");

	// After the final point of a term the block stops taking items to finish it.
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input ready right after a final point");

	// A new result only appears while the input side is held off.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result item appeared while input was ready");

	// A stalled result item holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result item changed");

endmodule

bind polyline_area_centroid pac_chk u_pac_chk (.*);

`default_nettype wire
